// ----- rtl/xdwm_pkg.sv -----
`timescale 1ns / 1ps

package xdwm_pkg;

   // Field widths
   localparam int AXIS_W  = 8;
   localparam int GAIN_W  = 7;
   localparam int DRIVE_W = 15;
   localparam int WHEELS  = 4;

   // Full drive in percent; the gain is in millivolts per percent
   localparam int FULL_SCALE = 100;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd94;

   // Internal widths, sized for stick values down to -128
   localparam int SUM_W      = AXIS_W + 1;   // |x|+|y|, y+x, y-x
   localparam int NUM_W      = 18;           // signed wheel numerator, |N| <= 65536
   localparam int MAG_W      = 17;           // |N| and the divisor
   localparam int S100_W     = 16;           // 100*s <= 25600
   localparam int SCALE_W    = 14;           // 100*gain <= 12700
   localparam int DIVIDEND_W = 30;           // |N|*100*gain < 2^30
   localparam int QUO_W      = 14;           // quotient <= 12700

   // Wheel lanes
   localparam int WHEEL_FL = 0;
   localparam int WHEEL_BL = 1;
   localparam int WHEEL_FR = 2;
   localparam int WHEEL_BR = 3;

   typedef logic signed [AXIS_W-1:0]  axis_type;
   typedef logic signed [DRIVE_W-1:0] drive_type;

   // Operands handed from the mixing stages to the divider
   typedef struct packed {
      logic [WHEELS-1:0]                 neg;
      logic [WHEELS-1:0][DIVIDEND_W-1:0] dividend;
      logic [MAG_W-1:0]                  divisor;
   } div_in_type;

endpackage

// ----- rtl/xdwm_if.sv -----
`timescale 1ns / 1ps

// Stick sample channel
interface xdwm_req_if;
   import xdwm_pkg::*;
   logic     valid;
   logic     ready;
   axis_type forward_axis;
   axis_type strafe_axis;
   axis_type turn_axis;
   modport source (output valid, forward_axis, strafe_axis, turn_axis, input ready);
   modport sink   (input valid, forward_axis, strafe_axis, turn_axis, output ready);
endinterface

// Wheel command channel
interface xdwm_rsp_if;
   import xdwm_pkg::*;
   logic      valid;
   logic      ready;
   drive_type front_left_drive;
   drive_type back_left_drive;
   drive_type front_right_drive;
   drive_type back_right_drive;
   modport source (output valid, front_left_drive, back_left_drive,
                   front_right_drive, back_right_drive, input ready);
   modport sink   (input valid, front_left_drive, back_left_drive,
                   front_right_drive, back_right_drive, output ready);
endinterface

// Gain register write channel
interface xdwm_csr_if;
   import xdwm_pkg::*;
   logic              valid;
   logic              ready;
   logic [GAIN_W-1:0] voltage_gain;
   modport source (output valid, voltage_gain, input ready);
   modport sink   (input valid, voltage_gain, output ready);
endinterface

// ----- rtl/xdwm_front.sv -----
`timescale 1ns / 1ps

// Mixing stages: stick magnitudes, products, wheel numerators, divisor and dividends.
module xdwm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [xdwm_pkg::SCALE_W-1:0]  scale_gain,
   xdwm_req_if.sink                      req_chan,
   output logic                          div_valid,
   input  logic                          div_ready,
   output xdwm_pkg::div_in_type          div_data
);
   import xdwm_pkg::*;

   // Stage advance chain, a stage moves when empty or when the next one moves
   logic adv1, adv2, adv3, adv4;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   assign adv4 = !s4_valid_ff || div_ready;
   assign adv3 = !s3_valid_ff || adv4;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign req_chan.ready = adv1;

   // ---------------- stage 1: magnitudes, sum, max, axis sums
   logic [AXIS_W-1:0]       abs_x, abs_y, peak_xy;
   logic [SUM_W-1:0]        sum_xy;
   logic                    still_xy;
   logic [SUM_W-1:0]        s1_scale_in, s1_scale_ff;
   logic [AXIS_W-1:0]       s1_peak_in, s1_peak_ff;
   logic signed [SUM_W-1:0] s1_plus_in, s1_plus_ff;
   logic signed [SUM_W-1:0] s1_minus_in, s1_minus_ff;
   axis_type                s1_turn_ff;

   always_comb begin
      // -128 maps to 128, which still fits eight unsigned bits
      abs_x    = req_chan.strafe_axis[AXIS_W-1]  ? AXIS_W'(-req_chan.strafe_axis)
                                                 : AXIS_W'(req_chan.strafe_axis);
      abs_y    = req_chan.forward_axis[AXIS_W-1] ? AXIS_W'(-req_chan.forward_axis)
                                                 : AXIS_W'(req_chan.forward_axis);
      sum_xy   = {1'b0, abs_x} + {1'b0, abs_y};
      peak_xy  = (abs_x > abs_y) ? abs_x : abs_y;
      still_xy = (sum_xy == '0);
      // Translation sticks at rest: no translation scale, turn only
      s1_scale_in = still_xy ? SUM_W'(1) : sum_xy;
      s1_peak_in  = still_xy ? '0 : peak_xy;
      s1_plus_in  = SUM_W'(req_chan.forward_axis) + SUM_W'(req_chan.strafe_axis);
      s1_minus_in = SUM_W'(req_chan.forward_axis) - SUM_W'(req_chan.strafe_axis);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_scale_ff <= s1_scale_in;
         s1_peak_ff  <= s1_peak_in;
         s1_plus_ff  <= s1_plus_in;
         s1_minus_ff <= s1_minus_in;
         s1_turn_ff  <= req_chan.turn_axis;
      end
   end

   // ---------------- stage 2: translation and turn products
   logic signed [NUM_W-1:0] plus_ext, minus_ext, turn_ext, peak_ext, scale_ext;
   logic signed [NUM_W-1:0] s2_plus_in, s2_plus_ff;
   logic signed [NUM_W-1:0] s2_minus_in, s2_minus_ff;
   logic signed [NUM_W-1:0] s2_turn_in, s2_turn_ff;
   logic [S100_W-1:0]       s2_s100_in, s2_s100_ff;

   always_comb begin
      plus_ext    = NUM_W'(s1_plus_ff);
      minus_ext   = NUM_W'(s1_minus_ff);
      turn_ext    = NUM_W'(s1_turn_ff);
      peak_ext    = NUM_W'({1'b0, s1_peak_ff});
      scale_ext   = NUM_W'({1'b0, s1_scale_ff});
      s2_plus_in  = NUM_W'(plus_ext * peak_ext);
      s2_minus_in = NUM_W'(minus_ext * peak_ext);
      s2_turn_in  = NUM_W'(turn_ext * scale_ext);
      s2_s100_in  = S100_W'(s1_scale_ff * FULL_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_plus_ff  <= s2_plus_in;
         s2_minus_ff <= s2_minus_in;
         s2_turn_ff  <= s2_turn_in;
         s2_s100_ff  <= s2_s100_in;
      end
   end

   // ---------------- stage 3: wheel numerators, split into sign and magnitude
   logic signed [NUM_W-1:0] num [WHEELS];
   logic [MAG_W-1:0]        s3_mag_in [WHEELS];
   logic [MAG_W-1:0]        s3_mag_ff [WHEELS];
   logic [WHEELS-1:0]       s3_neg_in, s3_neg_ff;
   logic [S100_W-1:0]       s3_s100_ff;

   always_comb begin
      // Sums stay inside the numerator range, so wrapping adds are exact
      num[WHEEL_FL] = s2_plus_ff  + s2_turn_ff;
      num[WHEEL_BL] = s2_minus_ff + s2_turn_ff;
      num[WHEEL_FR] = s2_minus_ff - s2_turn_ff;
      num[WHEEL_BR] = s2_plus_ff  - s2_turn_ff;
      for (int w = 0; w < WHEELS; w++) begin
         s3_neg_in[w] = num[w][NUM_W-1];
         s3_mag_in[w] = s3_neg_in[w] ? MAG_W'(-num[w]) : MAG_W'(num[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_mag_ff  <= s3_mag_in;
         s3_neg_ff  <= s3_neg_in;
         s3_s100_ff <= s2_s100_ff;
      end
   end

   // ---------------- stage 4: divisor = max(|N|, 100*s), dividends |N|*100*gain
   logic [MAG_W-1:0]  max_front, max_back, max_num;
   div_in_type        s4_data_in, s4_data_ff;

   always_comb begin
      max_front = (s3_mag_ff[WHEEL_FL] > s3_mag_ff[WHEEL_BL]) ? s3_mag_ff[WHEEL_FL]
                                                               : s3_mag_ff[WHEEL_BL];
      max_back  = (s3_mag_ff[WHEEL_FR] > s3_mag_ff[WHEEL_BR]) ? s3_mag_ff[WHEEL_FR]
                                                               : s3_mag_ff[WHEEL_BR];
      max_num   = (max_front > max_back) ? max_front : max_back;
      s4_data_in.divisor = (max_num > MAG_W'(s3_s100_ff)) ? max_num : MAG_W'(s3_s100_ff);
      s4_data_in.neg     = s3_neg_ff;
      for (int w = 0; w < WHEELS; w++) begin
         s4_data_in.dividend[w] = DIVIDEND_W'(s3_mag_ff[w]) * DIVIDEND_W'(scale_gain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign div_valid = s4_valid_ff;
   assign div_data  = s4_data_ff;

endmodule

// ----- rtl/xdwm_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage for four lanes, then sign and output register.
module xdwm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  xdwm_pkg::div_in_type  in_data,
   xdwm_rsp_if.source            rsp_chan
);
   import xdwm_pkg::*;

   localparam int TRIAL_W = DIVIDEND_W + 1;

   // Stage registers
   logic [QUO_W-1:0]      valid_ff;
   logic [DIVIDEND_W-1:0] rem_ff     [QUO_W][WHEELS];
   logic [QUO_W-1:0]      quo_ff     [QUO_W][WHEELS];
   logic [MAG_W-1:0]      divisor_ff [QUO_W];
   logic [WHEELS-1:0]     neg_ff     [QUO_W];

   // Stage inputs, stage 0 takes from the mixing stages
   logic                  src_valid   [QUO_W];
   logic [DIVIDEND_W-1:0] src_rem     [QUO_W][WHEELS];
   logic [QUO_W-1:0]      src_quo     [QUO_W][WHEELS];
   logic [MAG_W-1:0]      src_divisor [QUO_W];
   logic [WHEELS-1:0]     src_neg     [QUO_W];

   logic [QUO_W:0]        adv;
   logic                  out_valid_ff;
   drive_type             drive_in [WHEELS];
   drive_type             drive_ff [WHEELS];

   assign adv[QUO_W] = !out_valid_ff || rsp_chan.ready;
   assign in_ready   = adv[0];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;

      logic [TRIAL_W-1:0] shifted;
      logic [TRIAL_W-1:0] trial [WHEELS];
      logic [WHEELS-1:0]  take;

      assign adv[k] = !valid_ff[k] || adv[k+1];

      if (k == 0) begin : g_first
         assign src_valid[k]   = in_valid;
         assign src_divisor[k] = in_data.divisor;
         assign src_neg[k]     = in_data.neg;
         for (genvar w = 0; w < WHEELS; w++) begin : g_lane
            assign src_rem[k][w] = in_data.dividend[w];
            assign src_quo[k][w] = '0;
         end
      end else begin : g_next
         assign src_valid[k]   = valid_ff[k-1];
         assign src_divisor[k] = divisor_ff[k-1];
         assign src_neg[k]     = neg_ff[k-1];
         assign src_rem[k]     = rem_ff[k-1];
         assign src_quo[k]     = quo_ff[k-1];
      end

      // Trial subtract of the divisor aligned to this quotient bit
      always_comb begin
         shifted = TRIAL_W'(src_divisor[k]) << BIT;
         for (int w = 0; w < WHEELS; w++) begin
            trial[w] = {1'b0, src_rem[k][w]} - shifted;
            take[w]  = !trial[w][TRIAL_W-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            divisor_ff[k] <= src_divisor[k];
            neg_ff[k]     <= src_neg[k];
            for (int w = 0; w < WHEELS; w++) begin
               rem_ff[k][w] <= take[w] ? trial[w][DIVIDEND_W-1:0] : src_rem[k][w];
               quo_ff[k][w] <= {src_quo[k][w][QUO_W-2:0], take[w]};
            end
         end
      end
   end

   // Restore the sign: truncation toward zero falls out of dividing magnitudes
   always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
         drive_in[w] = neg_ff[QUO_W-1][w] ? -DRIVE_W'(quo_ff[QUO_W-1][w])
                                          : DRIVE_W'(quo_ff[QUO_W-1][w]);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv[QUO_W]) begin
         out_valid_ff <= valid_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[QUO_W]) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.front_left_drive  = drive_ff[WHEEL_FL];
   assign rsp_chan.back_left_drive   = drive_ff[WHEEL_BL];
   assign rsp_chan.front_right_drive = drive_ff[WHEEL_FR];
   assign rsp_chan.back_right_drive  = drive_ff[WHEEL_BR];

endmodule

// ----- rtl/x_drive_wheel_mixer.sv -----
`timescale 1ns / 1ps

// X-drive wheel mixer. Each transfer on req_chan (forward, strafe, turn stick values)
// yields one transfer on rsp_chan with four wheel commands in millivolts: the translation
// mix scaled by max(|x|,|y|)/(|x|+|y|), turn added on the left wheels and subtracted on
// the right, then normalized to full scale and multiplied by voltage_gain, truncating
// toward zero. The pipeline takes one sample per clock while its output is not stalled
// and holds 19 in flight in 19 register stages: four mixing stages, fourteen divider
// stages that each resolve one quotient bit of the exact normalizing division, and the
// output register. A stalled output backs up stage by stage, so bubbles still fill.
// csr_chan is always ready; write voltage_gain only while no sample is in flight.
module x_drive_wheel_mixer (
   input  logic        clock,
   input  logic        reset,
   xdwm_csr_if.sink    csr_chan,
   xdwm_req_if.sink    req_chan,
   xdwm_rsp_if.source  rsp_chan
);
   import xdwm_pkg::*;

   localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(int'(GAIN_RESET) * FULL_SCALE);

   // Gain register, kept premultiplied by full scale
   logic [SCALE_W-1:0] scale_gain_ff, scale_gain_in;

   assign csr_chan.ready = 1'b1;
   assign scale_gain_in  = SCALE_W'(csr_chan.voltage_gain) * SCALE_W'(FULL_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_gain_ff <= SCALE_RESET;
      end else if (csr_chan.valid) begin
         scale_gain_ff <= scale_gain_in;
      end
   end

   // Mixing stages to divider
   logic       div_valid;
   logic       div_ready;
   div_in_type div_data;

   xdwm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .scale_gain (scale_gain_ff),
      .req_chan   (req_chan),
      .div_valid  (div_valid),
      .div_ready  (div_ready),
      .div_data   (div_data)
   );

   xdwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_valid),
      .in_ready (div_ready),
      .in_data  (div_data),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import xdwm_pkg::*;

   // One wheel command set as the block presents it
   typedef struct packed {
      drive_type fl_mv;
      drive_type bl_mv;
      drive_type fr_mv;
      drive_type br_mv;
   } wheel_cmd_type;

   logic clock;
   logic reset;

   xdwm_req_if req_bus ();
   xdwm_rsp_if rsp_bus ();
   xdwm_csr_if csr_bus ();

   x_drive_wheel_mixer u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_bus),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Gain as the block should currently hold it
   logic [GAIN_W-1:0] gain_shadow;
   // Wheel commands predicted for accepted stick samples, oldest first
   wheel_cmd_type     pending_cmds[$];

   int req_gap_pct;
   int rsp_stall_pct;
   int fault_count;
   int samples_sent;
   int cmds_checked;
   int gain_writes;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Exact integer mix: numerators, shared divisor, truncating division
   function automatic wheel_cmd_type predict_wheel_cmds(axis_type fwd, axis_type strafe,
                                                        axis_type turn,
                                                        logic [GAIN_W-1:0] gain);
      longint        y, x, r, ax, ay, span, peak, divisor, g, mag;
      longint        num [WHEELS];
      longint        drive [WHEELS];
      wheel_cmd_type cmd;
      y  = fwd;
      x  = strafe;
      r  = turn;
      g  = gain;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      span = ax + ay;
      peak = (ax > ay) ? ax : ay;
      // no translation: scale step skipped, pure turn
      if (span == 0) begin
         span = 1;
         peak = 0;
      end
      num[WHEEL_FL] = (y + x) * peak + r * span;
      num[WHEEL_BL] = (y - x) * peak + r * span;
      num[WHEEL_FR] = (y - x) * peak - r * span;
      num[WHEEL_BR] = (y + x) * peak - r * span;
      divisor = FULL_SCALE * span;
      for (int i = 0; i < WHEELS; i++) begin
         mag = (num[i] < 0) ? -num[i] : num[i];
         if (mag > divisor) divisor = mag;
      end
      for (int i = 0; i < WHEELS; i++)
         drive[i] = (num[i] * FULL_SCALE * g) / divisor;
      cmd.fl_mv = drive_type'(drive[WHEEL_FL]);
      cmd.bl_mv = drive_type'(drive[WHEEL_BL]);
      cmd.fr_mv = drive_type'(drive[WHEEL_FR]);
      cmd.br_mv = drive_type'(drive[WHEEL_BR]);
      return cmd;
   endfunction

   function automatic void compare_drive(string field, drive_type want, drive_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         fault_count++;
      end
   endfunction

   // Receiver stalls
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result checker
   always @(posedge clock) begin
      wheel_cmd_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_cmds.size() == 0) begin
            $error("wheel command transfer with no stick sample pending");
            fault_count++;
         end else begin
            want = pending_cmds.pop_front();
            cmds_checked++;
            compare_drive("front_left_drive", want.fl_mv, rsp_bus.front_left_drive);
            compare_drive("back_left_drive", want.bl_mv, rsp_bus.back_left_drive);
            compare_drive("front_right_drive", want.fr_mv, rsp_bus.front_right_drive);
            compare_drive("back_right_drive", want.br_mv, rsp_bus.back_right_drive);
         end
      end
   end

   // One stick sample, with random gaps ahead of it; valid is left high
   task automatic send_sample(axis_type fwd, axis_type strafe, axis_type turn);
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.forward_axis <= fwd;
      req_bus.strafe_axis  <= strafe;
      req_bus.turn_axis    <= turn;
      do @(posedge clock); while (!req_bus.ready);
      pending_cmds.push_back(predict_wheel_cmds(fwd, strafe, turn, gain_shadow));
      samples_sent++;
   endtask

   // Hold off the sender until every pending command has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
   endtask

   task automatic write_gain(logic [GAIN_W-1:0] value);
      drain_results();
      csr_bus.valid        <= 1'b1;
      csr_bus.voltage_gain <= value;
      do @(posedge clock); while (!csr_bus.ready);
      gain_shadow = value;
      gain_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   // Stick value leaning toward the corners now and then
   function automatic axis_type pick_axis();
      case ($urandom_range(9))
         0:       return axis_type'(8'h80);
         1:       return axis_type'(8'h7F);
         2:       return axis_type'(8'h00);
         3:       return $urandom_range(1) ? axis_type'(8'h01) : axis_type'(8'hFF);
         default: return axis_type'($urandom_range(255));
      endcase
   endfunction

   // Corners and special cases at the reset gain
   task automatic test_reset_gain();
      send_sample(0, 0, 0);
      send_sample(127, 0, 0);
      send_sample(-128, 0, 0);
      send_sample(0, 127, 0);
      send_sample(0, -128, 0);
      send_sample(0, 0, 127);
      send_sample(0, 0, -128);
      send_sample(0, 0, 50);
      send_sample(0, 0, -1);
      send_sample(127, 127, 127);
      send_sample(-128, -128, -128);
      send_sample(127, -128, 0);
      send_sample(-1, 1, -1);
      send_sample(100, 30, -75);
   endtask

   // Gain extremes, including values above the nominal range
   task automatic test_gain_extremes();
      logic [GAIN_W-1:0] gains [4];
      gains = '{7'd0, 7'd127, 7'd120, 7'd1};
      foreach (gains[i]) begin
         write_gain(gains[i]);
         send_sample(-128, 127, -128);
         send_sample(3, -5, 120);
      end
   endtask

   // Random samples, gain changed every 50 items
   task automatic test_random_traffic(int gap_pct, int stall_pct, int count);
      axis_type fwd, strafe, turn;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) write_gain(GAIN_W'($urandom_range(127)));
         fwd    = pick_axis();
         strafe = pick_axis();
         turn   = pick_axis();
         // pure turn now and then
         if ($urandom_range(9) == 0) begin
            fwd    = 0;
            strafe = 0;
         end
         send_sample(fwd, strafe, turn);
      end
   endtask

   initial begin
      int guard;
      fault_count   = 0;
      samples_sent  = 0;
      cmds_checked  = 0;
      gain_writes   = 0;
      req_gap_pct   = 22;
      rsp_stall_pct = 62;
      gain_shadow   = GAIN_RESET;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.forward_axis <= '0;
      req_bus.strafe_axis  <= '0;
      req_bus.turn_axis    <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.voltage_gain <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_gain();
      test_gain_extremes();
      test_random_traffic(22, 62, 250);
      test_random_traffic(62, 22, 250);
      test_random_traffic(0, 0, 250);

      // Let the pipeline empty out
      req_bus.valid <= 1'b0;
      guard = 0;
      while (pending_cmds.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (25) @(posedge clock);
      if (pending_cmds.size() != 0) begin
         $error("%0d wheel commands never arrived", pending_cmds.size());
         fault_count++;
      end

      $display("Ran %0d stick samples, checked %0d wheel command sets over %0d gain writes,",
               samples_sent, cmds_checked, gain_writes);
      $display("with stick corners, pure turn and gains from 0 to 127 under mixed stalls.");
      if (fault_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
